// ===== rtl/sts_pkg.sv =====
// Package for the sorted table search block: table sizes, field widths
// and result status codes. No dependencies.
`timescale 1ns / 1ps

package sts_pkg;

	// Table geometry
	localparam int DEPTH = 64;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	// Word fields
	localparam int VAL_W    = 32;
	localparam int STATUS_W = 2;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FOUND    = 2'd2;
	localparam logic [STATUS_W-1:0] ST_MISSING  = 2'd3;

	// Action codes
	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_SEARCH = 1'b1;

endpackage

// ===== rtl/sorted_table_search.sv =====
// Sorted table search top level: sorted word table in a single-port memory,
// one shared comparator, and a one-hot sequencer. Depends on sts_pkg.
//
//   channel | signals                          | handshake
//   --------+----------------------------------+-------------------------------
//   command | action, value, start_new         | taken on start && !busy
//   result  | status, position, entries        | done high for one cycle
//
// An insert reads each larger entry and moves it up one place, then writes
// the word into the hole at entry 0 or above the first entry that is not
// larger. A search probes entry 0, then the last entry, then halves the open
// range until it finds the word or the range is empty. Every read goes
// through the one memory read port and its registered read data. A drop on
// a full table or a search of an empty one is not busy at all. done rises
// in the same cycle that busy falls. Reset empties the table; the memory
// itself is not cleared. The receiver cannot stall results.
`timescale 1ns / 1ps

module sorted_table_search (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic                         action,
	input  logic signed [sts_pkg::VAL_W-1:0] value,
	input  logic                         start_new,
	output logic                         done,
	output logic [sts_pkg::STATUS_W-1:0] status,
	output logic [sts_pkg::IDX_W-1:0]    position,
	output logic [sts_pkg::CNT_W-1:0]    entries
);
	import sts_pkg::*;

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_ICHK  = 8'b0000_0010,
		S_ICMP  = 8'b0000_0100,
		S_SRD0  = 8'b0000_1000,
		S_SCHK0 = 8'b0001_0000,
		S_SCHKL = 8'b0010_0000,
		S_SMID  = 8'b0100_0000,
		S_SCMP  = 8'b1000_0000
	} state_t;

	state_t                   state_q, state_d;
	logic [CNT_W-1:0]         count_q, count_d;
	logic [CNT_W-1:0]         j_q, j_d;
	logic [CNT_W-1:0]         lo_q, lo_d;
	logic [CNT_W-1:0]         hi_q, hi_d;
	logic [IDX_W-1:0]         mid_q, mid_d;
	logic signed [VAL_W-1:0]  key_q, key_d;
	logic                     done_q, done_d;
	logic [STATUS_W-1:0]      status_q, status_d;
	logic [IDX_W-1:0]         pos_q, pos_d;

	// Table memory with registered read
	logic signed [VAL_W-1:0]  mem [DEPTH];
	logic signed [VAL_W-1:0]  rd_data_q;
	logic                     rd_en;
	logic [IDX_W-1:0]         rd_addr;
	logic                     wr_en;
	logic [IDX_W-1:0]         wr_addr;
	logic signed [VAL_W-1:0]  wr_data;

	// Shared compare unit and probe arithmetic
	logic                     cmp_eq;
	logic                     cmp_lt;
	logic [CNT_W-1:0]         span;
	logic [CNT_W-1:0]         mid_full;
	logic [CNT_W-1:0]         last_idx;

	assign cmp_eq   = (rd_data_q == key_q);
	assign cmp_lt   = (key_q < rd_data_q);
	assign span     = hi_q - lo_q - CNT_W'(1);
	assign mid_full = lo_q + (span >> 1);
	assign last_idx = count_q - CNT_W'(1);

	assign busy     = (state_q != S_IDLE);
	assign done     = done_q;
	assign status   = status_q;
	assign position = pos_q;
	assign entries  = count_q;

	// Write and read the table
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// Sequencer
	always_comb begin
		state_d  = state_q;
		count_d  = count_q;
		j_d      = j_q;
		lo_d     = lo_q;
		hi_d     = hi_q;
		mid_d    = mid_q;
		key_d    = key_q;
		done_d   = 1'b0;
		status_d = status_q;
		pos_d    = pos_q;
		rd_en    = 1'b0;
		rd_addr  = '0;
		wr_en    = 1'b0;
		wr_addr  = j_q[IDX_W-1:0];
		wr_data  = key_q;

		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					key_d = value;
					if (action == ACT_INSERT) begin
						// Empty the table first on a fresh load
						if (start_new) begin
							count_d = '0;
							j_d     = '0;
							state_d = S_ICHK;
						end else if (count_q >= CNT_W'(DEPTH)) begin
							done_d   = 1'b1;
							status_d = ST_FULL;
							pos_d    = '0;
						end else begin
							j_d     = count_q;
							state_d = S_ICHK;
						end
					end else begin
						if (count_q == '0) begin
							done_d   = 1'b1;
							status_d = ST_MISSING;
							pos_d    = '0;
						end else begin
							state_d = S_SRD0;
						end
					end
				end
			end

			S_ICHK: begin
				// Place the word at the hole, or fetch the entry below it
				if (j_q == '0) begin
					wr_en    = 1'b1;
					count_d  = count_q + CNT_W'(1);
					done_d   = 1'b1;
					status_d = ST_INSERTED;
					pos_d    = '0;
					state_d  = S_IDLE;
				end else begin
					rd_en   = 1'b1;
					rd_addr = IDX_W'(j_q - CNT_W'(1));
					state_d = S_ICMP;
				end
			end

			S_ICMP: begin
				// Shift a larger entry up one place, else drop the word in
				wr_en = 1'b1;
				if (cmp_lt) begin
					wr_data = rd_data_q;
					j_d     = j_q - CNT_W'(1);
					state_d = S_ICHK;
				end else begin
					count_d  = count_q + CNT_W'(1);
					done_d   = 1'b1;
					status_d = ST_INSERTED;
					pos_d    = '0;
					state_d  = S_IDLE;
				end
			end

			S_SRD0: begin
				rd_en   = 1'b1;
				rd_addr = '0;
				state_d = S_SCHK0;
			end

			S_SCHK0: begin
				if (cmp_eq) begin
					done_d   = 1'b1;
					status_d = ST_FOUND;
					pos_d    = '0;
					state_d  = S_IDLE;
				end else begin
					rd_en   = 1'b1;
					rd_addr = last_idx[IDX_W-1:0];
					state_d = S_SCHKL;
				end
			end

			S_SCHKL: begin
				if (cmp_eq) begin
					done_d   = 1'b1;
					status_d = ST_FOUND;
					pos_d    = last_idx[IDX_W-1:0];
					state_d  = S_IDLE;
				end else begin
					lo_d    = '0;
					hi_d    = count_q;
					state_d = S_SMID;
				end
			end

			S_SMID: begin
				// Probe the middle of the open range, or report a miss
				if (lo_q < hi_q) begin
					mid_d   = mid_full[IDX_W-1:0];
					rd_en   = 1'b1;
					rd_addr = mid_full[IDX_W-1:0];
					state_d = S_SCMP;
				end else begin
					done_d   = 1'b1;
					status_d = ST_MISSING;
					pos_d    = '0;
					state_d  = S_IDLE;
				end
			end

			S_SCMP: begin
				if (cmp_eq) begin
					done_d   = 1'b1;
					status_d = ST_FOUND;
					pos_d    = mid_q;
					state_d  = S_IDLE;
				end else if (cmp_lt) begin
					hi_d    = {1'b0, mid_q};
					state_d = S_SMID;
				end else begin
					lo_d    = {1'b0, mid_q} + CNT_W'(1);
					state_d = S_SMID;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Hold control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			done_q  <= done_d;
		end
	end

	// Hold working and result words
	always_ff @(posedge clk) begin
		j_q      <= j_d;
		lo_q     <= lo_d;
		hi_q     <= hi_d;
		mid_q    <= mid_d;
		key_q    <= key_d;
		status_q <= status_d;
		pos_q    <= pos_d;
	end

endmodule
